@@ hdl/kcfr_pkg.sv @@
// Shared types, codes and the boot sequence code table for the keyboard controller.
package kcfr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_KEY    = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_SELECT = 3'd4;

    localparam logic [1:0] PORT_DATA   = 2'd0;
    localparam logic [1:0] PORT_STATUS = 2'd1;
    localparam logic [1:0] PORT_IRQ    = 2'd2;

    localparam logic [7:0] CMD_RESET_LONG  = 8'hA0;
    localparam logic [7:0] CMD_RESET_SHORT = 8'hA1;
    localparam logic [7:0] DATA_RESET_ALT  = 8'hA2;

    localparam logic [7:0] REPLY_0 = 8'hB0;
    localparam logic [7:0] REPLY_1 = 8'h7F;
    localparam logic [7:0] REPLY_2 = 8'hE8;
    localparam logic [7:0] REPLY_3 = 8'h25;

    localparam logic [7:0] BOOT_EVEN_EARLY = 8'hA0;
    localparam logic [7:0] BOOT_EVEN_LATE  = 8'hF0;
    localparam logic [7:0] BOOT_FIRST_ODD  = 8'h7F;
    localparam logic [7:0] BOOT_FAST       = 8'h15;
    localparam logic [7:0] BOOT_SLOW       = 8'h2F;
    localparam logic [7:0] READ_OTHER_DATA = 8'hFF;

    localparam logic [4:0] COMBO_LAST = 5'd14;
    localparam logic [3:0] SEL_NONE   = 4'd0;
    localparam logic [3:0] SEL_CD     = 4'd1;
    localparam logic [3:0] SEL_H4     = 4'd10;
    localparam logic [3:0] SEL_ICM    = 4'd11;
    localparam logic [3:0] SEL_DEBUG  = 4'd12;
    localparam logic [3:0] SEL_FAST   = 4'd13;
    localparam logic [3:0] SEL_SLOW   = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_KEY,
        OP_DATA_RESET,
        OP_CMD,
        OP_IRQ_WRITE,
        OP_READ_DATA,
        OP_READ_STATUS,
        OP_READ_IRQ,
        OP_READ_OTHER,
        OP_TICK,
        OP_SELECT
    } op_code_t;

    typedef struct packed {
        op_code_t   code;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } op_t;

    typedef struct packed {
        logic       schedule_tick;
        logic       irq_clear;
        logic       irq_set;
        logic [7:0] read_data;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ
    } back_state_t;

    function automatic logic [7:0] boot_code(input logic [3:0] sel, input logic [15:0] step,
                                             input logic [1:0] mod3, input logic [2:0] mod5);
        logic [14:0] num;
        logic [7:0]  code;
        num  = step[15:1];
        code = 8'h00;
        if (!step[0]) begin
            code = (num < 15'd6) ? BOOT_EVEN_EARLY : BOOT_EVEN_LATE;
        end
        else if (num == 15'd0) begin
            code = BOOT_FIRST_ODD;
        end
        else if (!num[0]) begin
            unique case (sel) inside
                SEL_CD:          code = 8'h2C;
                [4'd2:4'd5]:     code = 8'h21;
                [4'd6:SEL_H4]:   code = 8'h23;
                SEL_ICM:         code = (mod3 == 2'd0) ? 8'h18 : (mod3 == 2'd1) ? 8'h2C : 8'h30;
                SEL_DEBUG:       code = (mod5 == 3'd0) ? 8'h20 : (mod5 == 3'd1) ? 8'h13 :
                                        (mod5 == 3'd2) ? 8'h2E : (mod5 == 3'd3) ? 8'h17 : 8'h22;
                SEL_FAST:        code = BOOT_FAST;
                SEL_SLOW:        code = BOOT_SLOW;
                default:         code = 8'h00;
            endcase
        end
        else begin
            unique case (sel) inside
                SEL_CD:          code = 8'h20;
                4'd2, 4'd6:      code = 8'h0B;
                4'd3, 4'd7:      code = 8'h02;
                4'd4, 4'd8:      code = 8'h03;
                4'd5, 4'd9:      code = 8'h04;
                SEL_H4:          code = 8'h05;
                SEL_ICM:         code = (mod3 == 2'd0) ? 8'h18 : (mod3 == 2'd1) ? 8'h2C : 8'h30;
                SEL_DEBUG:       code = (mod5 == 3'd0) ? 8'h20 : (mod5 == 3'd1) ? 8'h13 :
                                        (mod5 == 3'd2) ? 8'h2E : (mod5 == 3'd3) ? 8'h17 : 8'h22;
                SEL_FAST:        code = BOOT_FAST;
                SEL_SLOW:        code = BOOT_SLOW;
                default:         code = 8'h00;
            endcase
        end
        return code;
    endfunction

endpackage

@@ hdl/kcfr_front.sv @@
// Input stage that accepts transactions and classifies them into back-end operations.
module kcfr_front
    import kcfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [1:0] port,
    input  logic [7:0] wdata,
    input  logic [7:0] key_flags,
    input  logic [7:0] key_code,
    input  logic [4:0] combo,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op
);

    logic op_valid_reg;
    logic op_valid_next;
    op_t  op_reg;
    op_t  op_next;
    op_t  decoded;

    always_comb
    begin
        decoded        = '0;
        decoded.code   = OP_NOP;
        decoded.byte_a = wdata;
        decoded.byte_b = 8'h00;
        unique case (kind)
            KIND_KEY:
            begin
                decoded.code   = OP_KEY;
                decoded.byte_a = key_flags;
                decoded.byte_b = key_code;
            end
            KIND_WRITE:
            begin
                unique case (port)
                    PORT_DATA:
                        if (wdata == CMD_RESET_SHORT || wdata == DATA_RESET_ALT)
                        begin
                            decoded.code = OP_DATA_RESET;
                        end
                    PORT_STATUS: decoded.code = OP_CMD;
                    PORT_IRQ:    decoded.code = OP_IRQ_WRITE;
                    default:     decoded.code = OP_NOP;
                endcase
            end
            KIND_READ:
            begin
                unique case (port)
                    PORT_DATA:   decoded.code = OP_READ_DATA;
                    PORT_STATUS: decoded.code = OP_READ_STATUS;
                    PORT_IRQ:    decoded.code = OP_READ_IRQ;
                    default:     decoded.code = OP_READ_OTHER;
                endcase
            end
            KIND_TICK: decoded.code = OP_TICK;
            KIND_SELECT:
            begin
                if (combo <= COMBO_LAST)
                begin
                    decoded.code   = OP_SELECT;
                    decoded.byte_a = {4'h0, combo[3:0]};
                end
            end
            default: decoded.code = OP_NOP;
        endcase
    end

    assign in_ready = !op_valid_reg || op_ready;

    always_comb
    begin
        op_valid_next = op_valid_reg && !op_ready;
        op_next       = op_reg;
        if (in_valid && in_ready)
        begin
            op_valid_next = 1'b1;
            op_next       = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

@@ hdl/kcfr_queue.sv @@
// Two-entry operation queue between the front and back stages.
module kcfr_queue
    import kcfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_op,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_op
);

    op_t        entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

@@ hdl/kcfr_back.sv @@
// Execution stage holding the byte FIFO, controller state and the result register.
module kcfr_back
    import kcfr_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    output logic    op_ready,
    input  op_t     op,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [7:0]      mem [FIFO_DEPTH];
    logic [7:0]      rdata_reg;
    logic            mem_we;

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   head_next;
    logic [AW-1:0]   tail_reg;
    logic [AW-1:0]   tail_next;
    logic            irq_en_reg;
    logic            irq_en_next;
    logic            pending_reg;
    logic            pending_next;
    logic [7:0]      prev_cmd_reg;
    logic [7:0]      prev_cmd_next;
    logic [3:0]      sel_reg;
    logic [3:0]      sel_next;
    logic [15:0]     step_reg;
    logic [15:0]     step_next;
    logic [1:0]      mod3_reg;
    logic [1:0]      mod3_next;
    logic [2:0]      mod5_reg;
    logic [2:0]      mod5_next;
    logic [3:0][7:0] push_data_reg;
    logic [3:0][7:0] push_data_next;
    logic [2:0]      push_left_reg;
    logic [2:0]      push_left_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    result_t         out_reg;
    result_t         out_next;
    logic            out_free;
    logic            longer;

    assign out_free = !out_valid_reg || res_ready;
    assign op_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        irq_en_next    = irq_en_reg;
        pending_next   = pending_reg;
        prev_cmd_next  = prev_cmd_reg;
        sel_next       = sel_reg;
        step_next      = step_reg;
        mod3_next      = mod3_reg;
        mod5_next      = mod5_reg;
        push_data_next = push_data_reg;
        push_left_next = push_left_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        longer         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    case (op.code)
                        OP_KEY:
                        begin
                            if (count_reg < CW'(FIFO_DEPTH - 1))
                            begin
                                push_data_next = {16'h0000, op.byte_b, op.byte_a};
                                push_left_next = 3'd2;
                                state_next     = ST_PUSH;
                            end
                            pending_next     = 1'b1;
                            out_next.irq_set = irq_en_reg;
                        end
                        OP_DATA_RESET:
                        begin
                            count_next       = '0;
                            head_next        = '0;
                            tail_next        = '0;
                            push_data_next   = {REPLY_3, REPLY_2, REPLY_1, REPLY_0};
                            push_left_next   = 3'd4;
                            state_next       = ST_PUSH;
                            pending_next     = 1'b1;
                            out_next.irq_set = irq_en_reg;
                        end
                        OP_CMD:
                        begin
                            prev_cmd_next = op.byte_a;
                            if (op.byte_a == CMD_RESET_LONG || op.byte_a == CMD_RESET_SHORT)
                            begin
                                longer = (op.byte_a == CMD_RESET_LONG) ||
                                         (prev_cmd_reg == CMD_RESET_LONG);
                                irq_en_next    = 1'b0;
                                pending_next   = 1'b1;
                                step_next      = 16'h0000;
                                mod3_next      = 2'd0;
                                mod5_next      = 3'd0;
                                count_next     = '0;
                                head_next      = '0;
                                tail_next      = '0;
                                push_data_next = {REPLY_3, REPLY_2, REPLY_1, REPLY_0};
                                push_left_next = longer ? 3'd4 : 3'd2;
                                state_next     = ST_PUSH;
                            end
                        end
                        OP_IRQ_WRITE:
                        begin
                            irq_en_next = op.byte_a[0];
                            if (op.byte_a[0] && count_reg != '0)
                            begin
                                pending_next     = 1'b1;
                                out_next.irq_set = 1'b1;
                            end
                        end
                        OP_READ_DATA:
                        begin
                            pending_next       = 1'b0;
                            out_next.irq_clear = 1'b1;
                            if (sel_reg != SEL_NONE)
                            begin
                                out_next.read_data = boot_code(sel_reg, step_reg, mod3_reg,
                                                               mod5_reg);
                                if (step_reg == 16'hFFFF)
                                begin
                                    step_next = 16'h0000;
                                    mod3_next = 2'd0;
                                    mod5_next = 3'd0;
                                end
                                else
                                begin
                                    step_next = step_reg + 16'd1;
                                    if (step_reg[0])
                                    begin
                                        mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                                        mod5_next = (mod5_reg == 3'd4) ? 3'd0 : mod5_reg + 3'd1;
                                    end
                                end
                            end
                            else if (count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = ST_READ;
                            end
                        end
                        OP_READ_STATUS:
                        begin
                            out_next.read_data = {7'd0, (count_reg != '0) || (sel_reg != SEL_NONE)};
                        end
                        OP_READ_IRQ:   out_next.read_data = {7'd0, pending_reg};
                        OP_READ_OTHER: out_next.read_data = READ_OTHER_DATA;
                        OP_TICK:
                        begin
                            if (count_reg != '0 && irq_en_reg)
                            begin
                                pending_next     = 1'b1;
                                out_next.irq_set = 1'b1;
                            end
                        end
                        OP_SELECT:
                        begin
                            sel_next  = op.byte_a[3:0];
                            step_next = 16'h0000;
                            mod3_next = 2'd0;
                            mod5_next = 3'd0;
                        end
                        default: out_next = '0;
                    endcase
                end
            end
            ST_PUSH:
            begin
                mem_we         = 1'b1;
                tail_next      = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_next     = count_reg + 1'b1;
                push_data_next = {8'h00, push_data_reg[3:1]};
                push_left_next = push_left_reg - 3'd1;
                if (push_left_reg == 3'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                out_valid_next         = 1'b1;
                out_next               = '0;
                out_next.read_data     = rdata_reg;
                out_next.irq_clear     = 1'b1;
                out_next.schedule_tick = (count_reg > CW'(1)) && irq_en_reg;
                head_next  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            irq_en_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            prev_cmd_reg  <= 8'h00;
            sel_reg       <= SEL_NONE;
            step_reg      <= 16'h0000;
            mod3_reg      <= 2'd0;
            mod5_reg      <= 3'd0;
            push_left_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            irq_en_reg    <= irq_en_next;
            pending_reg   <= pending_next;
            prev_cmd_reg  <= prev_cmd_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            mod3_reg      <= mod3_next;
            mod5_reg      <= mod5_next;
            push_left_reg <= push_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_data_reg <= push_data_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= push_data_reg[0];
        end
        rdata_reg <= mem[head_reg];
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("FIFO count exceeds depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("Empty FIFO with unequal pointers");

    a_read_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("Data read did not pop one byte");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("Result register busy during data read");

endmodule

@@ hdl/keyboard_controller_fifo_regs_unit.sv @@
// Top level of the keyboard controller with byte FIFO and port registers.
//
// Channel  Direction  Payload
// s_axis   in         tdata: wdata, key_flags, key_code, combo; tuser: kind, port
// m_axis   out        tdata: read_data, irq_set, irq_clear, schedule_tick
//
// One transaction goes through a decode register and a two-entry queue before execution.
// Most operations complete in the idle state; a data read from the FIFO goes on through a read
// state, as the byte memory has a registered read port.
// A stored key event writes two bytes and a reset command two or four, one per push step
// through the single memory write port.
// Reset clears all control state; FIFO contents are not cleared, only the count and pointers.
// A stalled result holds the back end, while the front end keeps accepting until the queue fills.
module keyboard_controller_fifo_regs_unit
    import kcfr_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // wdata[7:0], key_flags[15:8], key_code[23:16], combo[28:24]
    input  logic [4:0]  s_axis_tuser,  // kind[2:0], port[4:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // read_data[7:0], irq_set[8], irq_clear[9], schedule_tick[10]
);

    logic    front_valid;
    logic    front_ready;
    op_t     front_op;
    logic    queue_valid;
    logic    queue_ready;
    op_t     queue_op;
    result_t result;

    kcfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .kind      (s_axis_tuser[2:0]),
        .port      (s_axis_tuser[4:3]),
        .wdata     (s_axis_tdata[7:0]),
        .key_flags (s_axis_tdata[15:8]),
        .key_code  (s_axis_tdata[23:16]),
        .combo     (s_axis_tdata[28:24]),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    kcfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_op    (front_op),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_op    (queue_op)
    );

    kcfr_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_valid),
        .op_ready  (queue_ready),
        .op        (queue_op),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (result)
    );

    assign m_axis_tdata = {5'd0, result.schedule_tick, result.irq_clear, result.irq_set,
                           result.read_data};

endmodule

@@ dv/tb_keyboard_controller_fifo_regs_unit.sv @@
// Self-checking testbench for the keyboard controller FIFO and port register unit.
`timescale 1ns / 1ps

module tb_keyboard_controller_fifo_regs_unit
    import kcfr_pkg::*;
();

    localparam int         FIFO_DEPTH     = 256;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] PORT_OTHER     = 2'd3;
    localparam logic [2:0] KIND_UNUSED    = 3'd7;

    typedef enum int {
        MOOD_MIXED,
        MOOD_FILL,
        MOOD_DRAIN,
        MOOD_BOOT
    } mood_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] port;
        logic [7:0] wdata;
        logic [7:0] key_flags;
        logic [7:0] key_code;
        logic [4:0] combo;
    } port_access_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [4:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    port_access_t pending_accesses[$];
    result_t      expected_responses[$];
    port_access_t next_access;

    logic [7:0]  kb_fifo[$];
    logic        kb_irq_enabled = 1'b0;
    logic        kb_int_pending = 1'b0;
    logic [7:0]  kb_last_command = 8'h00;
    logic [3:0]  kb_boot_sel = SEL_NONE;
    logic [15:0] kb_boot_step = 16'h0000;

    int   error_count = 0;
    int   response_count = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   send_calm = 0;
    int   recv_gap = 0;
    int   recv_calm = 0;

    keyboard_controller_fifo_regs_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic push_pair(input logic [7:0] lead, input logic [7:0] trail);
        if (kb_fifo.size() + 1 < FIFO_DEPTH)
        begin
            kb_fifo.push_back(lead);
            kb_fifo.push_back(trail);
        end
        kb_int_pending = 1'b1;
        return kb_irq_enabled;
    endfunction

    function automatic logic [7:0] next_boot_byte();
        logic [14:0] num;
        logic        odd;
        logic [7:0]  code;
        int          n3;
        int          n5;
        odd = kb_boot_step[0];
        num = kb_boot_step[15:1];
        n3 = num % 3;
        n5 = num % 5;
        kb_boot_step = kb_boot_step + 16'd1;
        code = 8'h00;
        if (!odd)
            code = (num < 15'd6) ? BOOT_EVEN_EARLY : BOOT_EVEN_LATE;
        else if (num == 15'd0)
            code = BOOT_FIRST_ODD;
        else if (kb_boot_sel == SEL_CD)
            code = num[0] ? 8'h20 : 8'h2C;
        else if (kb_boot_sel >= 4'd2 && kb_boot_sel <= 4'd9)
        begin
            if (!num[0])
                code = (kb_boot_sel <= 4'd5) ? 8'h21 : 8'h23;
            else
            begin
                case (kb_boot_sel[1:0])
                    2'd2: code = 8'h0B;
                    2'd3: code = 8'h02;
                    2'd0: code = 8'h03;
                    default: code = 8'h04;
                endcase
            end
        end
        else if (kb_boot_sel == SEL_H4)
            code = num[0] ? 8'h05 : 8'h23;
        else if (kb_boot_sel == SEL_ICM)
            code = (n3 == 0) ? 8'h18 : (n3 == 1) ? 8'h2C : 8'h30;
        else if (kb_boot_sel == SEL_DEBUG)
        begin
            case (n5)
                0: code = 8'h20;
                1: code = 8'h13;
                2: code = 8'h2E;
                3: code = 8'h17;
                default: code = 8'h22;
            endcase
        end
        else if (kb_boot_sel == SEL_FAST)
            code = BOOT_FAST;
        else if (kb_boot_sel == SEL_SLOW)
            code = BOOT_SLOW;
        return code;
    endfunction

    task automatic predict_response(input logic [4:0] user, input logic [31:0] data);
        logic [2:0] kind;
        logic [1:0] port;
        logic [7:0] wdata;
        logic [4:0] combo;
        logic       longer;
        result_t    resp;
        kind = user[2:0];
        port = user[4:3];
        wdata = data[7:0];
        combo = data[28:24];
        resp = '0;
        case (kind)
            KIND_KEY:
                resp.irq_set = push_pair(data[15:8], data[23:16]);
            KIND_WRITE:
            begin
                if (port == PORT_DATA)
                begin
                    if (wdata == CMD_RESET_SHORT || wdata == DATA_RESET_ALT)
                    begin
                        kb_fifo.delete();
                        resp.irq_set = push_pair(REPLY_0, REPLY_1);
                        resp.irq_set = push_pair(REPLY_2, REPLY_3) | resp.irq_set;
                    end
                end
                else if (port == PORT_STATUS)
                begin
                    if (wdata == CMD_RESET_SHORT || wdata == CMD_RESET_LONG)
                    begin
                        longer = (wdata == CMD_RESET_LONG) ||
                                 (kb_last_command == CMD_RESET_LONG);
                        kb_irq_enabled = 1'b0;
                        kb_int_pending = 1'b0;
                        kb_boot_step = 16'h0000;
                        kb_fifo.delete();
                        resp.irq_set = push_pair(REPLY_0, REPLY_1);
                        if (longer)
                            resp.irq_set = push_pair(REPLY_2, REPLY_3) | resp.irq_set;
                    end
                    kb_last_command = wdata;
                end
                else if (port == PORT_IRQ)
                begin
                    kb_irq_enabled = wdata[0];
                    if (kb_irq_enabled && kb_fifo.size() > 0)
                    begin
                        kb_int_pending = 1'b1;
                        resp.irq_set = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                case (port)
                    PORT_DATA:
                    begin
                        resp.irq_clear = 1'b1;
                        kb_int_pending = 1'b0;
                        if (kb_boot_sel != SEL_NONE)
                            resp.read_data = next_boot_byte();
                        else if (kb_fifo.size() > 0)
                        begin
                            resp.read_data = kb_fifo.pop_front();
                            resp.schedule_tick = (kb_fifo.size() > 0) && kb_irq_enabled;
                        end
                    end
                    PORT_STATUS:
                        resp.read_data = (kb_fifo.size() > 0 || kb_boot_sel != SEL_NONE) ?
                                         8'h01 : 8'h00;
                    PORT_IRQ:
                        resp.read_data = {7'd0, kb_int_pending};
                    default:
                        resp.read_data = READ_OTHER_DATA;
                endcase
            end
            KIND_TICK:
            begin
                if (kb_fifo.size() > 0 && kb_irq_enabled)
                begin
                    kb_int_pending = 1'b1;
                    resp.irq_set = 1'b1;
                end
            end
            KIND_SELECT:
            begin
                if (combo <= COMBO_LAST)
                begin
                    kb_boot_sel = combo[3:0];
                    kb_boot_step = 16'h0000;
                end
            end
            default:
                resp = '0;
        endcase
        expected_responses.push_back(resp);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at response %0d: %s", response_count, msg);
    endtask

    task automatic check_response(input result_t got);
        result_t want;
        if (expected_responses.size() == 0)
            report_mismatch($sformatf("unexpected transaction with data %h", got));
        else
        begin
            want = expected_responses.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch($sformatf("read_data %h, expected %h",
                                          got.read_data, want.read_data));
            if (got.irq_set !== want.irq_set)
                report_mismatch($sformatf("irq_set %b, expected %b",
                                          got.irq_set, want.irq_set));
            if (got.irq_clear !== want.irq_clear)
                report_mismatch($sformatf("irq_clear %b, expected %b",
                                          got.irq_clear, want.irq_clear));
            if (got.schedule_tick !== want.schedule_tick)
                report_mismatch($sformatf("schedule_tick %b, expected %b",
                                          got.schedule_tick, want.schedule_tick));
        end
        response_count++;
    endtask

    task automatic draw_gap(inout int calm, output int gap);
        int r;
        r = $urandom_range(0, 99);
        gap = 0;
        if (calm > 0)
            calm--;
        else if (r < 3)
            calm = $urandom_range(20, 80);
        else if (r >= 88)
            gap = $urandom_range(6, 30);
        else if (r >= 50)
            gap = $urandom_range(1, 3);
    endtask

    function automatic port_access_t make_access(input logic [2:0] kind, input logic [1:0] port,
                                                 input logic [7:0] wdata, input logic [7:0] kflags,
                                                 input logic [7:0] kcode, input logic [4:0] combo);
        port_access_t acc;
        acc.kind = kind;
        acc.port = port;
        acc.wdata = wdata;
        acc.key_flags = kflags;
        acc.key_code = kcode;
        acc.combo = combo;
        return acc;
    endfunction

    function automatic port_access_t random_access(input mood_t mood);
        port_access_t acc;
        int           r;
        int           pick;
        acc = make_access(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        r = $urandom_range(0, 99);
        case (mood)
            MOOD_FILL:
            begin
                if (r < 92)
                    acc.kind = KIND_KEY;
                else if (r < 96)
                begin
                    acc.kind = KIND_WRITE;
                    acc.port = PORT_IRQ;
                end
                else
                    acc.kind = KIND_TICK;
            end
            MOOD_DRAIN:
            begin
                if (r < 60)
                begin
                    acc.kind = KIND_READ;
                    acc.port = PORT_DATA;
                end
                else if (r < 75)
                    acc.kind = KIND_READ;
                else if (r < 85)
                    acc.kind = KIND_TICK;
                else if (r < 92)
                    acc.kind = KIND_KEY;
                else
                begin
                    acc.kind = KIND_WRITE;
                    acc.port = PORT_IRQ;
                end
            end
            MOOD_BOOT:
            begin
                if (r < 4)
                begin
                    acc.kind = KIND_SELECT;
                    acc.combo = 5'($urandom_range(1, COMBO_LAST));
                end
                else if (r < 6)
                    acc.kind = KIND_SELECT;
                else if (r < 80)
                begin
                    acc.kind = KIND_READ;
                    acc.port = PORT_DATA;
                end
                else if (r < 88)
                begin
                    acc.kind = KIND_READ;
                    acc.port = PORT_STATUS;
                end
            end
            default:
            begin
                if (r < 20)
                    acc.kind = KIND_KEY;
                else if (r < 40)
                begin
                    acc.kind = KIND_READ;
                    acc.port = PORT_DATA;
                end
                else if (r < 45)
                    acc.kind = KIND_READ;
                else if (r < 60)
                begin
                    acc.kind = KIND_WRITE;
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        acc.wdata = CMD_RESET_LONG;
                    else if (pick == 1)
                        acc.wdata = CMD_RESET_SHORT;
                    else if (pick == 2)
                        acc.wdata = DATA_RESET_ALT;
                end
                else if (r < 68)
                    acc.kind = KIND_TICK;
                else if (r < 74)
                    acc.kind = KIND_SELECT;
            end
        endcase
        return acc;
    endfunction

    task automatic queue_random_phase(input int n_accesses);
        int    queued;
        int    seg;
        mood_t mood;
        queued = 0;
        while (queued < n_accesses)
        begin
            mood = mood_t'($urandom_range(0, 3));
            seg = (mood == MOOD_FILL) ? 170 : $urandom_range(40, 120);
            if (seg > n_accesses - queued)
                seg = n_accesses - queued;
            if (mood == MOOD_FILL || mood == MOOD_DRAIN)
                pending_accesses.push_back(make_access(KIND_SELECT, PORT_DATA, 8'h00, 8'h00,
                                                       8'h00, {1'b0, SEL_NONE}));
            repeat (seg)
                pending_accesses.push_back(random_access(mood));
            queued += seg;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_responses.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_response(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_accesses.size() > 0)
                begin
                    next_access = pending_accesses.pop_front();
                    s_axis_tdata <= {3'b000, next_access.combo, next_access.key_code,
                                     next_access.key_flags, next_access.wdata};
                    s_axis_tuser <= {next_access.port, next_access.kind};
                    s_axis_tvalid <= 1'b1;
                    draw_gap(send_calm, send_gap);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_response(m_axis_tdata[10:0]);
                draw_gap(recv_calm, recv_gap);
            end
            else if (recv_gap > 0)
                recv_gap--;
            m_axis_tready <= (recv_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keyboard_controller_fifo_regs_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        pending_accesses.push_back(make_access(KIND_READ, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_STATUS, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_IRQ, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_OTHER, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_OTHER, 8'hFF, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_KEY, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_KEY, PORT_OTHER, 8'h00, 8'hFF, 8'hFF, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_IRQ, 8'h01, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_TICK, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_IRQ, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_STATUS, 8'h55, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_STATUS, CMD_RESET_LONG,
                                               8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_STATUS, CMD_RESET_SHORT,
                                               8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_STATUS, CMD_RESET_SHORT,
                                               8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_DATA, DATA_RESET_ALT,
                                               8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_DATA, CMD_RESET_SHORT,
                                               8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_WRITE, PORT_IRQ, 8'hFE, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_SELECT, PORT_DATA, 8'h00, 8'h00, 8'h00,
                                               {1'b0, SEL_ICM}));
        pending_accesses.push_back(make_access(KIND_READ, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_DATA, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_READ, PORT_STATUS, 8'h00, 8'h00, 8'h00, 5'd0));
        pending_accesses.push_back(make_access(KIND_SELECT, PORT_DATA, 8'h00, 8'h00, 8'h00,
                                               5'd31));
        pending_accesses.push_back(make_access(KIND_SELECT, PORT_DATA, 8'h00, 8'h00, 8'h00,
                                               {1'b0, SEL_NONE}));
        pending_accesses.push_back(make_access(KIND_UNUSED, PORT_OTHER, 8'hFF, 8'hFF, 8'hFF,
                                               5'd31));
        wait_drained();

        queue_random_phase(680);
        wait_drained();
        queue_random_phase(680);
        wait_drained();

        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0)
            $display("keyboard_controller_fifo_regs_unit verification clean");
        else
            $display("keyboard_controller_fifo_regs_unit verification failed");
        $finish;
    end

endmodule
